/* hdl/bisc_pkg.sv */
package bisc_pkg;

  // Field and register widths fixed by the block's interface.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 32;
  localparam int COORD_W   = 8;
  localparam int CH_W      = 8;
  localparam int N_CH      = 4;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  // Register reset value and legal limits.
  localparam int             CFG_RESET = 256;
  localparam logic [CFG_W-1:0] SRC_MIN = 9'd2;
  localparam logic [CFG_W-1:0] DST_MIN = 9'd1;
  localparam logic [CFG_W-1:0] DST_MAX = 9'd256;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H = 2'd3;

  // Item actions.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // write the incoming pixel into the frame store
    logic       cap;       // capture the clamped destination coordinate
    logic       pos;       // form source position and fractions
    logic       acc_clr;   // clear the channel accumulators
    logic       rd;        // read one neighbor and form its weight
    logic [1:0] sel;       // neighbor: bit 0 is the column offset, bit 1 the row offset
    logic       mul;       // multiply the read neighbor by its weight
    logic       acc;       // add the weighted neighbor into the accumulators
    logic       out_load;  // load the packed result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;            // step division pending or in progress
  } stat_t;

endpackage

/* hdl/bisc_if.sv */
interface bisc_item_if import bisc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [PIX_W-1:0]   pixel_in;
  logic [COORD_W-1:0] dst_col;
  logic [COORD_W-1:0] dst_row;

  modport source (output valid, action, pixel_in, dst_col, dst_row, input ready);
  modport sink   (input valid, action, pixel_in, dst_col, dst_row, output ready);
endinterface

interface bisc_res_if import bisc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

/* hdl/bisc_div.sv */
module bisc_div #(
  parameter int NW = 25,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW:0]     rem_sh;
  logic            fits;

  // Restoring division, one quotient bit per cycle, numerator shifted out
  // of the same register that collects the quotient.
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNTW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NW-2:0], fits};
      rem_q <= fits ? DW'(rem_sh - {1'b0, den_i}) : DW'(rem_sh);
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

/* hdl/bisc_dp.sv */
module bisc_dp import bisc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [PIX_W-1:0]     pixel_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [COORD_W-1:0]   row_i,
  output logic [PIX_W-1:0]     pixel_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = CFG_W + FRAC_BITS;      // step width
  localparam int PW    = COORD_W + SW;           // position width
  localparam int FW    = FRAC_BITS + 1;          // one weight factor
  localparam int WW    = 2 * FW;                 // full neighbor weight
  localparam int PRW   = CH_W + WW;              // weighted channel and sum
  localparam int RW    = PRW - 2 * FRAC_BITS;    // integer part of the sum
  localparam int SRC_W_RST = (MAX_WIDTH < CFG_RESET) ? MAX_WIDTH : CFG_RESET;
  localparam int SRC_H_RST = (MAX_HEIGHT < CFG_RESET) ? MAX_HEIGHT : CFG_RESET;
  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Configuration and load position.
  logic [CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [CFG_W-1:0] src_w_c, src_h_c, dst_c;
  logic [XW-1:0]    load_col_q;
  logic [YW-1:0]    load_row_q;
  logic             start_q;

  // Step division.
  logic [SW-1:0] col_step, row_step;
  logic          col_busy, row_busy;

  // Interpolation datapath.
  logic [COORD_W-1:0]   col_q, row_q;
  logic [PW-1:0]        px, py;
  logic [XW-1:0]        x_q;
  logic [YW-1:0]        y_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [FW-1:0]        hfac, vfac;
  logic [WW-1:0]        w_q;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [PIX_W-1:0]     mem_q [DEPTH];
  logic [PIX_W-1:0]     rdata_q;
  logic [PRW-1:0]       prod_q [N_CH];
  logic [PRW-1:0]       acc_q  [N_CH];
  logic [RW-1:0]        ch_int [N_CH];
  logic [PIX_W-1:0]     pix_d, pix_q;

  // Register clamping on write.
  always_comb begin
    if (cfg_data_i < SRC_MIN) begin
      src_w_c = SRC_MIN;
      src_h_c = SRC_MIN;
    end else begin
      src_w_c = (32'(cfg_data_i) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : cfg_data_i;
      src_h_c = (32'(cfg_data_i) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : cfg_data_i;
    end
    if (cfg_data_i < DST_MIN) begin
      dst_c = DST_MIN;
    end else if (cfg_data_i > DST_MAX) begin
      dst_c = DST_MAX;
    end else begin
      dst_c = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q    <= CFG_W'(SRC_W_RST);
      src_h_q    <= CFG_W'(SRC_H_RST);
      dst_w_q    <= CFG_W'(CFG_RESET);
      dst_h_q    <= CFG_W'(CFG_RESET);
      load_col_q <= '0;
      load_row_q <= '0;
      start_q    <= 1'b1;
    end else begin
      start_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SRC_W: src_w_q <= src_w_c;
          REG_SRC_H: src_h_q <= src_h_c;
          REG_DST_W: dst_w_q <= dst_c;
          REG_DST_H: dst_h_q <= dst_c;
        endcase
        load_col_q <= '0;
        load_row_q <= '0;
      end else if (cmd_i.load) begin
        if (32'(load_col_q) + 32'd1 >= 32'(src_w_q)) begin
          load_col_q <= '0;
          if (32'(load_row_q) + 32'd1 >= 32'(src_h_q)) begin
            load_row_q <= '0;
          end else begin
            load_row_q <= load_row_q + 1'b1;
          end
        end else begin
          load_col_q <= load_col_q + 1'b1;
        end
      end
    end
  end

  // Steps are recomputed after reset and after every register write.
  bisc_div #(.NW(SW), .DW(CFG_W)) u_col_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .num_i  ({CFG_W'(src_w_q - 1'b1), {FRAC_BITS{1'b0}}}),
    .den_i  (dst_w_q),
    .busy_o (col_busy),
    .quo_o  (col_step)
  );

  bisc_div #(.NW(SW), .DW(CFG_W)) u_row_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .num_i  ({CFG_W'(src_h_q - 1'b1), {FRAC_BITS{1'b0}}}),
    .den_i  (dst_h_q),
    .busy_o (row_busy),
    .quo_o  (row_step)
  );

  assign stat_o.busy = start_q | col_busy | row_busy | cfg_we_i;

  // Coordinate capture with saturation, then position and fractions.
  assign px = col_q * col_step;
  assign py = row_q * row_step;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      col_q <= (CFG_W'(col_i) >= dst_w_q) ? COORD_W'(dst_w_q - 1'b1) : col_i;
      row_q <= (CFG_W'(row_i) >= dst_h_q) ? COORD_W'(dst_h_q - 1'b1) : row_i;
    end
    if (cmd_i.pos) begin
      x_q  <= px[FRAC_BITS +: XW];
      y_q  <= py[FRAC_BITS +: YW];
      fx_q <= px[FRAC_BITS-1:0];
      fy_q <= py[FRAC_BITS-1:0];
    end
  end

  // Frame store: one access per cycle, either the load write or a neighbor read.
  assign wr_addr = AW'(32'(load_row_q) * MAX_WIDTH + 32'(load_col_q));
  assign rd_addr = AW'((32'(y_q) + 32'(cmd_i.sel[1])) * MAX_WIDTH
                       + 32'(x_q) + 32'(cmd_i.sel[0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[wr_addr] <= pixel_i;
    end else if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // The weight of the neighbor being read lines up with its read data.
  assign hfac = cmd_i.sel[0] ? {1'b0, fx_q} : ONE - {1'b0, fx_q};
  assign vfac = cmd_i.sel[1] ? {1'b0, fy_q} : ONE - {1'b0, fy_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      w_q <= hfac * vfac;
    end
    for (int c = 0; c < N_CH; c++) begin
      if (cmd_i.mul) begin
        prod_q[c] <= PRW'(rdata_q[c*CH_W +: CH_W]) * PRW'(w_q);
      end
      if (cmd_i.acc_clr) begin
        acc_q[c] <= '0;
      end else if (cmd_i.acc) begin
        acc_q[c] <= acc_q[c] + prod_q[c];
      end
    end
    if (cmd_i.out_load) begin
      pix_q <= pix_d;
    end
  end

  // Truncate each channel sum to its integer part and saturate.
  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      ch_int[c] = acc_q[c][2*FRAC_BITS +: RW];
      pix_d[c*CH_W +: CH_W] = (|ch_int[c][RW-1:CH_W]) ? {CH_W{1'b1}} : ch_int[c][CH_W-1:0];
    end
  end

  assign pixel_o = pix_q;

endmodule

/* hdl/bisc_ctrl.sv */
module bisc_ctrl import bisc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_action_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_READ,
    ST_DRAIN,
    ST_WRITE
  } state_e;

  localparam logic [1:0] NBR_LAST   = 2'd3;
  localparam logic [1:0] DRAIN_LAST = 2'd1;
  localparam logic [1:0] NBR_THIRD  = 2'd2;

  state_e     state_q;
  logic [1:0] cnt_q;
  logic       out_valid_q;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE) && !stat_i.busy;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  // Neighbor reads, weighting and accumulation overlap in a pipeline.
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept && (in_action_i == ACT_LOAD);
    cmd_o.cap      = accept && (in_action_i == ACT_EMIT);
    cmd_o.pos      = state_q == ST_POS;
    cmd_o.acc_clr  = state_q == ST_POS;
    cmd_o.rd       = state_q == ST_READ;
    cmd_o.sel      = cnt_q;
    cmd_o.mul      = ((state_q == ST_READ) && (cnt_q != 2'd0))
                  || ((state_q == ST_DRAIN) && (cnt_q != DRAIN_LAST));
    cmd_o.acc      = ((state_q == ST_READ) && (cnt_q >= NBR_THIRD))
                  || (state_q == ST_DRAIN);
    cmd_o.out_load = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.cap) begin
            state_q <= ST_POS;
          end
        end
        ST_POS: begin
          state_q <= ST_READ;
          cnt_q   <= '0;
        end
        ST_READ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == NBR_LAST) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DRAIN_LAST) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (cmd_o.out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/bilinear_image_scaler_unit.sv */
// Bilinear ARGB8888 image scaler. A load item writes its pixel into the
// frame store at the next raster position and produces no result; an emit
// item maps its destination coordinate (saturated to the destination size)
// onto the source frame with a fixed-point step of (src-1)/dst and returns
// the 2x2 neighborhood blended per channel with bilinear weights, truncated.
// A load item leaves the controller idle for the next item. An emit item
// occupies the block from its transfer to the next possible input transfer:
// the position multiply, the four neighbor reads from the single-port frame
// store, a drain to weight and accumulate the last neighbor, the load of the
// output register, and an idle state in which the next item transfers. The
// output register lets the next item transfer while a result still waits to
// be taken; a second emit then holds in its output-load cycle until the
// register is free. After reset and after every register write the two
// steps are recomputed by bit-serial dividers, during which no item
// transfers; configuration writes are taken at any time and also restart
// loading at the first pixel. The frame store is not cleared: emit only
// positions whose neighbors have been loaded.
module bilinear_image_scaler_unit import bisc_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bisc_item_if.sink            item_i,
  bisc_res_if.source           result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of loads, neighbor reads and the output handshake.
  bisc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_action_i(item_i.action),
    .in_ready_o (item_i.ready),
    .out_valid_o(result_o.valid),
    .out_ready_i(result_o.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Registers, step division, frame store and interpolation arithmetic.
  bisc_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pixel_i   (item_i.pixel_in),
    .col_i     (item_i.dst_col),
    .row_i     (item_i.dst_row),
    .pixel_o   (result_o.pixel_out)
  );

endmodule
